// File: src/assert_macros.svh
// Assertion macros for the fade engine.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define AST_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define AST_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define AST_IMP(lbl, clk, rst, ante, cons)
`define AST_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

// File: src/rlfe_pkg.sv
// Shared types, constants and helpers of the LED fade engine.
`default_nettype none
package rlfe_pkg;
   localparam int NUM_LEDS_DEF = 32;
   localparam int MAX_EMIT     = 32;
   localparam int DIV_NUM_W    = 24;
   localparam int DIV_DEN_W    = 16;
   localparam int DIV_CNT_W    = 5;
   localparam logic [DIV_NUM_W-1:0] FADE_NUM = DIV_NUM_W'(4095);
   localparam logic OP_SET  = 1'b0;
   localparam logic OP_TICK = 1'b1;

   typedef struct packed {
      logic [23:0] cur;
      logic [23:0] tgt;
      logic [15:0] dur;
      logic [15:0] el;
   } fade_entry_type;

   // x / 255 for x <= 65279, exact via reciprocal
   function automatic logic [7:0] div255(input logic [15:0] x);
      logic [32:0] p;
      p = {17'd0, x} * 33'd32897;
      return p[30:23];
   endfunction
endpackage
`default_nettype wire

// File: src/rlfe_div.sv
// Radix-2 restoring divider, one quotient bit per cycle.
`default_nettype none
module rlfe_div (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   input  wire logic [rlfe_pkg::DIV_NUM_W-1:0] num,
   input  wire logic [rlfe_pkg::DIV_DEN_W-1:0] den,
   output logic                                busy,
   output logic                                done,
   output logic [rlfe_pkg::DIV_NUM_W-1:0]      quot
);
   import rlfe_pkg::*;

   logic [DIV_DEN_W-1:0] rem_ff, rem_in;
   logic [DIV_NUM_W-1:0] quo_ff, quo_in;
   logic [DIV_DEN_W-1:0] den_ff, den_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_DEN_W:0]   trial;

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, quo_ff[DIV_NUM_W-1]};
      if (start) begin
         rem_in  = '0;
         quo_in  = num;
         den_in  = den;
         cnt_in  = DIV_CNT_W'(DIV_NUM_W - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = DIV_DEN_W'(trial - {1'b0, den_ff});
            quo_in = {quo_ff[DIV_NUM_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DIV_DEN_W-1:0];
            quo_in = {quo_ff[DIV_NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
   end

   assign busy = busy_ff;
   assign done = done_ff;
   assign quot = quo_ff;
endmodule
`default_nettype wire

// File: src/rgb_led_fade_engine.sv
// Per-LED linear color fade engine with a level-scaled frame buffer.
// A set beat takes one item at a time: an immediate color passes RD, EVAL,
// SCL1 and SCL2, a fade start passes RD, EVAL and DIV, which waits on the
// 24-step shared divider; both start in the idle state that accepts the beat.
// A tick beat walks every LED through the state memory: RD, EVAL, OUT when
// idle, RD, EVAL, SCL1, SCL2, OUT when its fade ends, DIV (the divider again),
// MIX1 and MIX2 added while still fading; OUT waits while the result side
// stalls. Memories reset through valid bits, so there is no clearing pass.
`default_nettype none
module rgb_led_fade_engine #(
   parameter int NUM_LEDS = rlfe_pkg::NUM_LEDS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_op,
   input  wire logic [4:0]  req_led_index,
   input  wire logic [23:0] req_new_color,
   input  wire logic [7:0]  req_fade_speed,
   input  wire logic [15:0] req_delta_ms,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [4:0]       rsp_out_index,
   output logic [23:0]      rsp_out_color,
   output logic             rsp_last,
   input  wire logic        csr_wr_en,
   input  wire logic [7:0]  csr_wr_data
);
   import rlfe_pkg::*;

   localparam int AW = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
   localparam int NumEmit = (NUM_LEDS < MAX_EMIT) ? NUM_LEDS : MAX_EMIT;

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_RD   = 4'd1;
   localparam logic [3:0] ST_EVAL = 4'd2;
   localparam logic [3:0] ST_DIV  = 4'd3;
   localparam logic [3:0] ST_MIX1 = 4'd4;
   localparam logic [3:0] ST_MIX2 = 4'd5;
   localparam logic [3:0] ST_SCL1 = 4'd6;
   localparam logic [3:0] ST_SCL2 = 4'd7;
   localparam logic [3:0] ST_OUT  = 4'd8;

   logic [3:0]     state_ff, state_in;
   logic           op_ff, op_in;
   logic [23:0]    color_ff, color_in;
   logic [7:0]     speed_ff, speed_in;
   logic [15:0]    delta_ff, delta_in;
   logic [AW-1:0]  cnt_ff, cnt_in;
   logic [7:0]     level_ff;
   fade_entry_type ent_ff, ent_in;
   logic [15:0]    el_ff, el_in;
   logic [7:0]     t_ff, t_in;
   logic [15:0]    prod_ff [3];
   logic [15:0]    prod_in [3];
   logic [2:0]     neg_ff, neg_in;
   logic [23:0]    mix_ff, mix_in;
   logic [23:0]    res_ff, res_in;

   fade_entry_type st_mem [NUM_LEDS];
   logic [23:0]    fb_mem [NUM_LEDS];
   logic [NUM_LEDS-1:0] st_vld_ff, fb_vld_ff;
   fade_entry_type rd_st_ff;
   logic [23:0]    rd_fb_ff;
   logic           rd_stv_ff, rd_fbv_ff;
   logic           st_we, fb_we;
   fade_entry_type st_wdata;
   logic [23:0]    fb_wdata;

   logic           rsp_valid_ff;
   logic [4:0]     rsp_index_ff;
   logic [23:0]    rsp_color_ff;
   logic           rsp_last_ff;
   logic           out_load, rsp_last_in;

   logic                 div_start, div_busy, div_done;
   logic [DIV_NUM_W-1:0] div_num, div_q;
   logic [DIV_DEN_W-1:0] div_den;

   fade_entry_type ent;
   logic [23:0]    fbv, scaled;
   logic [16:0]    el_sum;
   logic [15:0]    el_sat;
   logic [7:0]     ca, cb;
   logic [8:0]     diff;
   logic [7:0]     mag, q8;
   logic           at_end;

   rlfe_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .busy  (div_busy),
      .done  (div_done),
      .quot  (div_q)
   );

   always_comb begin
      ent    = rd_stv_ff ? rd_st_ff : '0;
      fbv    = rd_fbv_ff ? rd_fb_ff : '0;
      el_sum = {1'b0, ent.el} + {1'b0, delta_ff};
      el_sat = el_sum[16] ? 16'hffff : el_sum[15:0];
      scaled = {div255(prod_ff[2]), div255(prod_ff[1]), div255(prod_ff[0])};
      if (op_ff == OP_SET) begin
         div_num = FADE_NUM;
         div_den = {8'd0, speed_ff};
      end else begin
         div_num = {el_sat, 8'd0} - {8'd0, el_sat};
         div_den = ent.dur;
      end
      at_end      = (cnt_ff == AW'(NUM_LEDS - 1));
      rsp_last_in = (cnt_ff == AW'(NumEmit - 1));
   end

   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      color_in  = color_ff;
      speed_in  = speed_ff;
      delta_in  = delta_ff;
      cnt_in    = cnt_ff;
      ent_in    = ent_ff;
      el_in     = el_ff;
      t_in      = t_ff;
      prod_in   = prod_ff;
      neg_in    = neg_ff;
      mix_in    = mix_ff;
      res_in    = res_ff;
      st_we     = 1'b0;
      st_wdata  = ent_ff;
      fb_we     = 1'b0;
      fb_wdata  = scaled;
      div_start = 1'b0;
      out_load  = 1'b0;
      ca = '0; cb = '0; diff = '0; mag = '0; q8 = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_in    = req_op;
               color_in = req_new_color;
               speed_in = req_fade_speed;
               delta_in = req_delta_ms;
               if (req_op == OP_TICK) begin
                  cnt_in   = '0;
                  state_in = ST_RD;
               end else if (int'(req_led_index) < NUM_LEDS) begin
                  cnt_in   = AW'(req_led_index);
                  state_in = ST_RD;
               end
            end
         end
         ST_RD: state_in = ST_EVAL;
         ST_EVAL: begin
            ent_in = ent;
            if (op_ff == OP_SET) begin
               if (speed_ff != 8'd0) begin
                  div_start = 1'b1;
                  state_in  = ST_DIV;
               end else begin
                  st_we    = 1'b1;
                  st_wdata = '{cur: color_ff, tgt: ent.tgt, dur: 16'd0, el: ent.el};
                  mix_in   = color_ff;
                  state_in = ST_SCL1;
               end
            end else if (ent.dur == 16'd0) begin
               res_in   = fbv;
               state_in = ST_OUT;
            end else begin
               el_in = el_sat;
               if (el_sat >= ent.dur) begin
                  st_we    = 1'b1;
                  st_wdata = '{cur: ent.tgt, tgt: ent.tgt, dur: 16'd0, el: el_sat};
                  mix_in   = ent.tgt;
                  state_in = ST_SCL1;
               end else begin
                  div_start = 1'b1;
                  state_in  = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            if (div_done) begin
               if (op_ff == OP_SET) begin
                  st_we    = 1'b1;
                  st_wdata = '{cur: ent_ff.cur, tgt: color_ff,
                               dur: {1'b0, div_q[11:0], 3'b000}, el: 16'd0};
                  state_in = ST_IDLE;
               end else begin
                  t_in     = div_q[7:0];
                  state_in = ST_MIX1;
               end
            end
         end
         ST_MIX1: begin
            for (int k = 0; k < 3; k++) begin
               ca   = ent_ff.cur[k*8 +: 8];
               cb   = ent_ff.tgt[k*8 +: 8];
               diff = {1'b0, cb} - {1'b0, ca};
               neg_in[k]  = diff[8];
               mag        = diff[8] ? 8'(-diff) : diff[7:0];
               prod_in[k] = {8'd0, mag} * {8'd0, t_ff};
            end
            state_in = ST_MIX2;
         end
         ST_MIX2: begin
            for (int k = 0; k < 3; k++) begin
               ca = ent_ff.cur[k*8 +: 8];
               q8 = div255(prod_ff[k]);
               mix_in[k*8 +: 8] = neg_ff[k] ? (ca - q8) : (ca + q8);
            end
            st_we    = 1'b1;
            st_wdata = '{cur: ent_ff.cur, tgt: ent_ff.tgt, dur: ent_ff.dur, el: el_ff};
            state_in = ST_SCL1;
         end
         ST_SCL1: begin
            for (int k = 0; k < 3; k++) begin
               prod_in[k] = {8'd0, mix_ff[k*8 +: 8]} * {8'd0, level_ff};
            end
            state_in = ST_SCL2;
         end
         ST_SCL2: begin
            fb_we    = 1'b1;
            res_in   = scaled;
            state_in = (op_ff == OP_SET) ? ST_IDLE : ST_OUT;
         end
         ST_OUT: begin
            if (int'(cnt_ff) >= NumEmit || !rsp_valid_ff || !rsp_stall) begin
               out_load = (int'(cnt_ff) < NumEmit);
               if (at_end) begin
                  state_in = ST_IDLE;
               end else begin
                  cnt_in   = cnt_ff + 1'b1;
                  state_in = ST_RD;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (st_we) begin
         st_mem[cnt_ff] <= st_wdata;
      end
      if (fb_we) begin
         fb_mem[cnt_ff] <= fb_wdata;
      end
      rd_st_ff  <= st_mem[cnt_ff];
      rd_fb_ff  <= fb_mem[cnt_ff];
      rd_stv_ff <= st_vld_ff[cnt_ff];
      rd_fbv_ff <= fb_vld_ff[cnt_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         level_ff     <= 8'hff;
         st_vld_ff    <= '0;
         fb_vld_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) begin
            level_ff <= csr_wr_data;
         end
         if (st_we) begin
            st_vld_ff[cnt_ff] <= 1'b1;
         end
         if (fb_we) begin
            fb_vld_ff[cnt_ff] <= 1'b1;
         end
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      op_ff    <= op_in;
      color_ff <= color_in;
      speed_ff <= speed_in;
      delta_ff <= delta_in;
      cnt_ff   <= cnt_in;
      ent_ff   <= ent_in;
      el_ff    <= el_in;
      t_ff     <= t_in;
      prod_ff  <= prod_in;
      neg_ff   <= neg_in;
      mix_ff   <= mix_in;
      res_ff   <= res_in;
      if (out_load) begin
         rsp_index_ff <= 5'(cnt_ff);
         rsp_color_ff <= res_ff;
         rsp_last_ff  <= rsp_last_in;
      end
   end

   assign req_stall     = (state_ff != ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_index = rsp_index_ff;
   assign rsp_out_color = rsp_color_ff;
   assign rsp_last      = rsp_last_ff;

`include "assert_macros.svh"
   `AST_IMP(a_div_in_div, clock, reset, div_busy, state_ff == ST_DIV)
   `AST_IMP(a_eval_after_rd, clock, reset, state_ff == ST_EVAL, $past(state_ff) == ST_RD)
   `AST_NXT(a_last_ends, clock, reset, out_load && rsp_last_in, state_ff == ST_IDLE)
endmodule
`default_nettype wire
